// ===== hw/rtl/dmbpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth map point lookup package
// Shared types, codes and default sizes of the bilinear point lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmbpl_pkg;

    localparam int unsigned MAP_DEPTH_DEF   = 524288;
    localparam int unsigned POINT_DEPTH_DEF = 524288;
    localparam int unsigned FRAC_BITS_DEF   = 8;

    localparam int unsigned DIM_W   = 11;
    localparam int unsigned COUNT_W = 20;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned ADDR_W  = 19;
    localparam int unsigned VAL_W   = 20;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned QPOS_W  = 20;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 20;

    localparam logic [DIM_W-1:0]   RST_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 11'd480;
    localparam logic [COUNT_W-1:0] RST_COUNT  = 20'd0;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY    = 2'd0,
        OP_WR_MAP   = 2'd1,
        OP_WR_POINT = 2'd2
    } t_op;

    typedef enum logic [CIDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_COUNT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MAPADDR,
        S_MAPRD,
        S_MAPCHK,
        S_PTRD,
        S_MUL,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op                        op;
        logic [ADDR_W-1:0]          addr;
        logic signed [VAL_W-1:0]    map_value;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic signed [QPOS_W-1:0]   qx;
        logic signed [QPOS_W-1:0]   qy;
    } t_item;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COUNT_W-1:0] count;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/depth_map_bilinear_point_lookup.sv =====
// ----------------------------------------------------------------------------
// Depth map bilinear point lookup
// Maps a sub-pixel image position to a blended 3-D point through an index map.
// ----------------------------------------------------------------------------
//
// Channel       Direction  Handshake                Payload
// item in       input      start high, busy low     op, entry_address, map_value,
//                                                   point_x/y/z, query_x/y
// result out    output     o_valid strobe, 1 cycle  found, out_x/y/z
// config write  input      i_cfg_valid, o_cfg_ready i_cfg_index, i_cfg_data
//
// A write item is done in the back end's decode state. A query that passes all
// checks walks the four neighbors through the address, read and check states on
// the single-ported index map, then through the read and multiply states on the
// single-ported point store, where one shared multiplier forms the three weighted
// coordinates one after another. A rejected query ends as soon as the failing
// check is seen. The result is registered and shows for one cycle only.
// Reset is synchronous and active low; it clears the queue, the sequencer and
// the configuration registers. The memories are not cleared.
// A two-entry queue sits between front and back, so busy rises only while it
// is full. The result receiver cannot stall the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module depth_map_bilinear_point_lookup import dmbpl_pkg::*; #(
    parameter int unsigned MAP_DEPTH   = MAP_DEPTH_DEF,
    parameter int unsigned POINT_DEPTH = POINT_DEPTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [OP_W-1:0]            i_op,
    input  wire logic [ADDR_W-1:0]          i_entry_address,
    input  wire logic signed [VAL_W-1:0]    i_map_value,
    input  wire logic signed [COORD_W-1:0]  i_point_x,
    input  wire logic signed [COORD_W-1:0]  i_point_y,
    input  wire logic signed [COORD_W-1:0]  i_point_z,
    input  wire logic signed [QPOS_W-1:0]   i_query_x,
    input  wire logic signed [QPOS_W-1:0]   i_query_y,
    output logic                            o_valid,
    output logic                            o_found,
    output logic signed [COORD_W-1:0]       o_out_x,
    output logic signed [COORD_W-1:0]       o_out_y,
    output logic signed [COORD_W-1:0]       o_out_z,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CIDX_W-1:0]          i_cfg_index,
    input  wire logic [CDATA_W-1:0]         i_cfg_data
);

    // Configuration registers. Writes to an index past the list are dropped.
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.count  <= RST_COUNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[DIM_W-1:0];
                CFG_COUNT:  r_cfg.count  <= i_cfg_data[COUNT_W-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    // Front end: accepts items and queues the known operations.
    logic  item_valid;
    logic  item_take;
    t_item item;

    dmbpl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_op            (i_op),
        .i_entry_address (i_entry_address),
        .i_map_value     (i_map_value),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_z       (i_point_z),
        .i_query_x       (i_query_x),
        .i_query_y       (i_query_y),
        .o_busy          (busy),
        .o_item_valid    (item_valid),
        .o_item          (item),
        .i_item_take     (item_take)
    );

    // Back end: memory writes and the query sequence.
    dmbpl_back #(
        .MAP_DEPTH   (MAP_DEPTH),
        .POINT_DEPTH (POINT_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/dmbpl_front.sv =====
// ----------------------------------------------------------------------------
// Front end of the point lookup
// Accepts items, drops unknown operations and queues the rest for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmbpl_front import dmbpl_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [OP_W-1:0]            i_op,
    input  wire logic [ADDR_W-1:0]          i_entry_address,
    input  wire logic signed [VAL_W-1:0]    i_map_value,
    input  wire logic signed [COORD_W-1:0]  i_point_x,
    input  wire logic signed [COORD_W-1:0]  i_point_y,
    input  wire logic signed [COORD_W-1:0]  i_point_z,
    input  wire logic signed [QPOS_W-1:0]   i_query_x,
    input  wire logic signed [QPOS_W-1:0]   i_query_y,
    output logic                            o_busy,
    output logic                            o_item_valid,
    output t_item                           o_item,
    input  wire logic                       i_item_take
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       op_known;
    logic       push;
    logic       pop;
    t_item      in_item;

    assign op_known = (i_op == OP_QUERY) || (i_op == OP_WR_MAP) || (i_op == OP_WR_POINT);
    assign o_busy   = (r_cnt == 2'd2);
    assign push     = i_start && !o_busy && op_known;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop      = i_item_take && o_item_valid;
    assign o_item   = r_q[r_rp];

    always_comb begin
        in_item.op        = t_op'(i_op);
        in_item.addr      = i_entry_address;
        in_item.map_value = i_map_value;
        in_item.px        = i_point_x;
        in_item.py        = i_point_y;
        in_item.pz        = i_point_z;
        in_item.qx        = i_query_x;
        in_item.qy        = i_query_y;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dmbpl_back.sv =====
// ----------------------------------------------------------------------------
// Back end of the point lookup
// Holds the index map and point store and runs the bilinear query sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmbpl_back import dmbpl_pkg::*; #(
    parameter int unsigned MAP_DEPTH   = MAP_DEPTH_DEF,
    parameter int unsigned POINT_DEPTH = POINT_DEPTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cfg                       i_cfg,
    input  wire logic                       i_item_valid,
    input  wire t_item                      i_item,
    output logic                            o_item_take,
    output logic                            o_valid,
    output logic                            o_found,
    output logic signed [COORD_W-1:0]       o_out_x,
    output logic signed [COORD_W-1:0]       o_out_y,
    output logic signed [COORD_W-1:0]       o_out_z
);

    localparam int unsigned MAP_AW  = $clog2(MAP_DEPTH);
    localparam int unsigned PT_AW   = $clog2(POINT_DEPTH);
    localparam int unsigned CHK_W   = 21;
    localparam int unsigned MADDR_W = 2 * DIM_W + 1;
    localparam int unsigned FW_W    = FRAC_BITS + 1;
    localparam int unsigned W_W     = 2 * FW_W;
    localparam int unsigned PROD_W  = W_W + 1 + COORD_W;
    localparam int unsigned ACC_W   = PROD_W + 2;
    localparam int unsigned PT_W    = 3 * COORD_W;
    localparam logic [FW_W-1:0] ONE = FW_W'(1) << FRAC_BITS;

    logic [VAL_W-1:0] m_map [MAP_DEPTH];
    logic [PT_W-1:0]  m_pt  [POINT_DEPTH];
    logic [VAL_W-1:0] r_map_rd;
    logic [PT_W-1:0]  r_pt_rd;

    t_state r_state;
    t_state n_state;

    t_item                      r_item;
    logic                       r_ok;
    logic [FRAC_BITS-1:0]       r_fx;
    logic [FRAC_BITS-1:0]       r_fy;
    logic [DIM_W-1:0]           r_x1;
    logic [DIM_W-1:0]           r_x2;
    logic [DIM_W-1:0]           r_y1;
    logic [DIM_W-1:0]           r_y2;
    logic [1:0]                 r_k;
    logic [1:0]                 r_c;
    logic [MADDR_W-1:0]         r_maddr;
    logic [PT_AW-1:0]           r_idx [4];
    logic [W_W-1:0]             r_w;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_v;
    logic [1:0]                 r_prod_c;
    logic signed [ACC_W-1:0]    r_acc [3];
    logic                       r_valid;
    logic                       r_found;
    logic signed [COORD_W-1:0]  r_ox;
    logic signed [COORD_W-1:0]  r_oy;
    logic signed [COORD_W-1:0]  r_oz;

    // Query decode.
    logic [FRAC_BITS-1:0]       fx;
    logic [FRAC_BITS-1:0]       fy;
    logic signed [QPOS_W-1:0]   x1f;
    logic signed [QPOS_W-1:0]   y1f;
    logic signed [QPOS_W:0]     x2f;
    logic signed [QPOS_W:0]     y2f;
    logic                       bounds_ok;

    assign fx  = r_item.qx[FRAC_BITS-1:0];
    assign fy  = r_item.qy[FRAC_BITS-1:0];
    assign x1f = r_item.qx >>> FRAC_BITS;
    assign y1f = r_item.qy >>> FRAC_BITS;
    assign x2f = {x1f[QPOS_W-1], x1f} + (QPOS_W+1)'(fx != '0);
    assign y2f = {y1f[QPOS_W-1], y1f} + (QPOS_W+1)'(fy != '0);
    assign bounds_ok = !x1f[QPOS_W-1] && !y1f[QPOS_W-1]
                    && ($unsigned(x2f) < (QPOS_W+1)'(i_cfg.width))
                    && ($unsigned(y2f) < (QPOS_W+1)'(i_cfg.height));

    // Index checks.
    logic signed [VAL_W-1:0] map_v;
    logic                    idx_ok;
    logic                    maddr_ok;
    logic                    wmap_ok;
    logic                    wpt_ok;

    assign map_v    = $signed(r_map_rd);
    assign idx_ok   = !map_v[VAL_W-1]
                   && (r_map_rd < i_cfg.count)
                   && (CHK_W'(r_map_rd) < CHK_W'(POINT_DEPTH));
    assign maddr_ok = (r_maddr < MADDR_W'(MAP_DEPTH));
    assign wmap_ok  = (CHK_W'(r_item.addr) < CHK_W'(MAP_DEPTH));
    assign wpt_ok   = (CHK_W'(r_item.addr) < CHK_W'(POINT_DEPTH));

    // Neighbor selection: bit 0 of the neighbor number picks the right column,
    // bit 1 the lower row.
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic [FW_W-1:0]  xf;
    logic [FW_W-1:0]  yf;

    assign col = r_k[0] ? r_x2 : r_x1;
    assign row = r_k[1] ? r_y2 : r_y1;
    assign xf  = r_k[0] ? FW_W'(r_fx) : ONE - FW_W'(r_fx);
    assign yf  = r_k[1] ? FW_W'(r_fy) : ONE - FW_W'(r_fy);

    logic signed [COORD_W-1:0] coord;
    assign coord = $signed(r_pt_rd[COORD_W*r_c +: COORD_W]);

    // Control decode.
    logic map_we;
    logic map_re;
    logic pt_we;
    logic pt_re;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_item.op)
                    OP_QUERY: n_state = bounds_ok ? S_MAPADDR : S_OUT;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_MAPADDR: n_state = S_MAPRD;
            S_MAPRD:   n_state = maddr_ok ? S_MAPCHK : S_OUT;
            S_MAPCHK: begin
                if (!idx_ok) begin
                    n_state = S_OUT;
                end else if (r_k == 2'd3) begin
                    n_state = S_PTRD;
                end else begin
                    n_state = S_MAPADDR;
                end
            end
            S_PTRD: n_state = S_MUL;
            S_MUL: begin
                if (r_c == 2'd2) begin
                    n_state = (r_k == 2'd3) ? S_DRAIN : S_PTRD;
                end
            end
            S_DRAIN: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_item_take = 1'b0;
        map_we      = 1'b0;
        map_re      = 1'b0;
        pt_we       = 1'b0;
        pt_re       = 1'b0;
        unique case (r_state)
            S_IDLE:   o_item_take = i_item_valid;
            S_DECODE: begin
                map_we = (r_item.op == OP_WR_MAP) && wmap_ok;
                pt_we  = (r_item.op == OP_WR_POINT) && wpt_ok;
            end
            S_MAPRD:  map_re = maddr_ok;
            S_PTRD:   pt_re  = 1'b1;
            default: begin
                o_item_take = 1'b0;
            end
        endcase
    end

    // Single-ported memories.
    logic [MAP_AW-1:0] map_addr;
    assign map_addr = map_we ? MAP_AW'(r_item.addr) : MAP_AW'(r_maddr);

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            m_map[map_addr] <= r_item.map_value;
        end else if (map_re) begin
            r_map_rd <= m_map[map_addr];
        end
    end

    logic [PT_AW-1:0] pt_addr;
    assign pt_addr = pt_we ? PT_AW'(r_item.addr) : r_idx[r_k];

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            m_pt[pt_addr] <= {r_item.pz, r_item.py, r_item.px};
        end else if (pt_re) begin
            r_pt_rd <= m_pt[pt_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prod_v <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prod_v <= (r_state == S_MUL);
            r_valid  <= (r_state == S_OUT);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_item <= i_item;
        end
        if (r_prod_v) begin
            r_acc[r_prod_c] <= r_acc[r_prod_c] + ACC_W'(r_prod);
        end
        unique case (r_state)
            S_DECODE: begin
                r_ok  <= bounds_ok;
                r_fx  <= fx;
                r_fy  <= fy;
                r_x1  <= x1f[DIM_W-1:0];
                r_y1  <= y1f[DIM_W-1:0];
                r_x2  <= x2f[DIM_W-1:0];
                r_y2  <= y2f[DIM_W-1:0];
                r_k   <= 2'd0;
                for (int i = 0; i < 3; i++) begin
                    r_acc[i] <= '0;
                end
            end
            S_MAPADDR: begin
                r_maddr <= MADDR_W'(row) * MADDR_W'(i_cfg.width) + MADDR_W'(col);
            end
            S_MAPRD: begin
                if (!maddr_ok) begin
                    r_ok <= 1'b0;
                end
            end
            S_MAPCHK: begin
                if (idx_ok) begin
                    r_idx[r_k] <= PT_AW'(r_map_rd);
                    r_k        <= r_k + 2'd1;
                end else begin
                    r_ok <= 1'b0;
                end
            end
            S_PTRD: begin
                r_w <= xf * yf;
                r_c <= 2'd0;
            end
            S_MUL: begin
                r_prod   <= $signed({1'b0, r_w}) * coord;
                r_prod_c <= r_c;
                r_c      <= r_c + 2'd1;
                if (r_c == 2'd2) begin
                    r_k <= r_k + 2'd1;
                end
            end
            S_OUT: begin
                r_found <= r_ok;
                r_ox    <= r_ok ? r_acc[0][2*FRAC_BITS +: COORD_W] : '0;
                r_oy    <= r_ok ? r_acc[1][2*FRAC_BITS +: COORD_W] : '0;
                r_oz    <= r_ok ? r_acc[2][2*FRAC_BITS +: COORD_W] : '0;
            end
            default: begin
                r_c <= r_c;
            end
        endcase
    end

    assign o_valid = r_valid;
    assign o_found = r_valid && r_found;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_out_z = r_oz;

endmodule

`default_nettype wire

// ===== hw/rtl/dmbpl_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the point lookup
// Watches the top level's ports for result and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmbpl_checker import dmbpl_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      busy,
    input wire logic                      o_valid,
    input wire logic                      o_found,
    input wire logic signed [COORD_W-1:0] o_out_x,
    input wire logic signed [COORD_W-1:0] o_out_y,
    input wire logic signed [COORD_W-1:0] o_out_z
);

    // Each query ends in an idle step, so results never come back to back.
    a_no_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results in adjacent cycles");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_out_x == 0 && o_out_y == 0 && o_out_z == 0))
        else $error("rejected query with nonzero coordinates");

    a_found_strobe: assert property (@(posedge i_clk)
        o_found |-> o_valid)
        else $error("found without result strobe");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("activity right after reset");

endmodule

bind depth_map_bilinear_point_lookup dmbpl_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_valid (o_valid),
    .o_found (o_found),
    .o_out_x (o_out_x),
    .o_out_y (o_out_y),
    .o_out_z (o_out_z)
);

`default_nettype wire
